// ===== rtl/aesk_pkg.sv =====
// ============================================================================
// aesk_pkg
// Shared types, constants and byte functions for the AES-128 key schedule.
// ============================================================================
package aesk_pkg;

    // Schedule geometry
    localparam int unsigned SCHED_WORDS = 44;
    localparam int unsigned KEY_WORDS   = 4;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned POS_W       = $clog2(KEY_WORDS);
    localparam int unsigned NUM_W       = $clog2(SCHED_WORDS);

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [NUM_W-1:0]  t_num;

    localparam t_pos       POS_LAST  = t_pos'(KEY_WORDS - 1);
    localparam t_num       NUM_FIRST = t_num'(KEY_WORDS);
    localparam t_num       NUM_LAST  = t_num'(SCHED_WORDS - 1);
    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] GF_POLY   = 8'h1b;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // write the key word into the window
        logic step;       // produce the next run word and shift the window
        logic rot;        // this run word takes rotate, S-box and round constant
        logic rcon_init;  // restart the round constant
        logic out_load;   // capture a result into the output register
        t_pos pos;        // window slot for a key word
        t_num number;     // schedule index of the result
    } t_cmd;

    // Forward S-box
    function automatic logic [7:0] sbox(input logic [7:0] b);
        logic [7:0] r;
        unique case (b)
            8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
            8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
            8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
            8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
            8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
            8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
            8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
            8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
            8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
            8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
            8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
            8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
            8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
            8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
            8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
            8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
            8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
            8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
            8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
            8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
            8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
            8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
            8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
            8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
            8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
            8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
            8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
            8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
            8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
            8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
            8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
            8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
            8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
            8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
            8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
            8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
            8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
            8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
            8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
            8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
            8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
            8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
            8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
            8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
            8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
            8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
            8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
            8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
            8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
            8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
            8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
            8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
            8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
            8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
            8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
            8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
            8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
            8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
            8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
            8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
            8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
            8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
            8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
            8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // S-box on each byte of a word
    function automatic t_word sub_word(input t_word w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

endpackage

// ===== rtl/aesk_key_if.sv =====
// ============================================================================
// aesk_key_if
// Key word channel: valid/ready handshake with key word and its position.
// ============================================================================
interface aesk_key_if;
    logic               valid;
    logic               ready;
    logic [31:0]        key_word;
    logic [1:0]         word_position;

    modport source (output valid, output key_word, output word_position, input ready);
    modport sink   (input valid, input key_word, input word_position, output ready);
endinterface

// ===== rtl/aesk_rkey_if.sv =====
// ============================================================================
// aesk_rkey_if
// Round key channel: valid/ready handshake with one schedule word.
// ============================================================================
interface aesk_rkey_if;
    logic               valid;
    logic               ready;
    logic [31:0]        round_key_word;
    logic [5:0]         word_number;
    logic               last_word;

    modport source (output valid, output round_key_word, output word_number,
                    output last_word, input ready);
    modport sink   (input valid, input round_key_word, input word_number,
                    input last_word, output ready);
endinterface

// ===== rtl/aes128_key_expansion.sv =====
// ============================================================================
// aes128_key_expansion
// AES-128 key schedule: four key words in, 44 round-key words out.
// ============================================================================
//
//  channel   dir  handshake      payload
//  i_key     in   valid/ready    key_word[31:0], word_position[1:0]
//  o_rkey    out  valid/ready    round_key_word[31:0], word_number[5:0], last_word
//
//  A key word at positions 0 to 2 gives one word.
//  A key word at position 3 gives its echo and then 40 run words, one per
//  cycle while the output takes them, all from the single word unit behind
//  the window.
//  No key word is taken while a run is in progress.
//  Reset (synchronous, active low) clears the controller and output valid
//  and restarts the round constant.
//  A stalled output holds its word and pauses the run in place.
//
module aes128_key_expansion (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aesk_key_if.sink    i_key,
    aesk_rkey_if.source o_rkey
);
    import aesk_pkg::*;

    t_cmd  cmd;
    t_num  out_num;

    // Controller
    aesk_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_key_valid     (i_key.valid),
        .i_word_position (i_key.word_position),
        .o_key_ready     (i_key.ready),
        .i_out_ready     (o_rkey.ready),
        .o_out_valid     (o_rkey.valid),
        .o_cmd           (cmd)
    );

    // Datapath
    aesk_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_key_word       (i_key.key_word),
        .o_round_key_word (o_rkey.round_key_word),
        .o_word_number    (out_num),
        .o_last_word      (o_rkey.last_word)
    );

    assign o_rkey.word_number = out_num;

endmodule

// ===== rtl/aesk_ctrl.sv =====
// ============================================================================
// aesk_ctrl
// Controller: key load handshake, run sequencing and output valid.
// ============================================================================
module aesk_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_key_valid,
    input  aesk_pkg::t_pos      i_word_position,
    output logic                o_key_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output aesk_pkg::t_cmd      o_cmd
);
    import aesk_pkg::*;

    t_state r_state, n_state;
    t_num   r_idx, n_idx;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    // Output register can take a word when empty or being drained
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // State, index and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= NUM_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_key_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_key_ready = slot_free;
                o_cmd.pos   = i_word_position;
                o_cmd.number = t_num'(i_word_position);
                if (i_key_valid && slot_free) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.out_load = 1'b1;
                    if (i_word_position == POS_LAST) begin
                        o_cmd.rcon_init = 1'b1;
                        n_idx   = NUM_FIRST;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.number = r_idx;
                o_cmd.rot    = (r_idx[POS_W-1:0] == '0);
                if (slot_free) begin
                    o_cmd.step     = 1'b1;
                    o_cmd.out_load = 1'b1;
                    if (r_idx == NUM_LAST) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + t_num'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // Hold valid until the transfer, set on a fresh word
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

// ===== rtl/aesk_datapath.sv =====
// ============================================================================
// aesk_datapath
// Word window, round constant, schedule word logic and output register.
// ============================================================================
module aesk_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aesk_pkg::t_cmd      i_cmd,
    input  aesk_pkg::t_word     i_key_word,
    output aesk_pkg::t_word     o_round_key_word,
    output aesk_pkg::t_num      o_word_number,
    output logic                o_last_word
);
    import aesk_pkg::*;

    // Window as a shift line: slot 0 is the word four back, slot 3 the newest
    t_word      r_win [KEY_WORDS];
    logic [7:0] r_rcon;
    t_word      r_out_word;
    t_num       r_out_num;
    logic       r_out_last;

    t_word      rot_word;
    t_word      n_word;

    // Next schedule word from the newest and the oldest window words
    always_comb begin
        rot_word = {r_win[KEY_WORDS-1][23:0], r_win[KEY_WORDS-1][31:24]};
        if (i_cmd.rot) begin
            n_word = sub_word(rot_word) ^ {r_rcon, 24'h000000} ^ r_win[0];
        end else begin
            n_word = r_win[KEY_WORDS-1] ^ r_win[0];
        end
    end

    // Load key words by position, shift during the run
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_win[i_cmd.pos] <= i_key_word;
        end else if (i_cmd.step) begin
            for (int k = 0; k < KEY_WORDS - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[KEY_WORDS-1] <= n_word;
        end
    end

    // Round constant: restart per run, advance after each rotated word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcon <= RCON_INIT;
        end else if (i_cmd.rcon_init) begin
            r_rcon <= RCON_INIT;
        end else if (i_cmd.step && i_cmd.rot) begin
            r_rcon <= xtime(r_rcon);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_word <= i_cmd.load ? i_key_word : n_word;
            r_out_num  <= i_cmd.number;
            r_out_last <= (i_cmd.number == NUM_LAST);
        end
    end

    assign o_round_key_word = r_out_word;
    assign o_word_number    = r_out_num;
    assign o_last_word      = r_out_last;

endmodule
